// ===== hdl/mcf_pkg.sv =====
// Shared types and constants for the music crossfade controller.
`default_nettype none

package mcf_pkg;

   // Fixed field widths
   localparam int MODE_W    = 2;
   localparam int ELAPSED_W = 16;
   localparam int LEN_W     = 24;
   localparam int SHAPE_W   = 2;
   localparam int STATE_W   = 3;
   localparam int TIMER_W   = 32;

   // Shortest fade in microseconds
   localparam logic [LEN_W-1:0] FADE_FLOOR_US = 24'd10000;

   // Request kinds; the unused code is ignored
   typedef enum logic [MODE_W-1:0] {
      MODE_TICK = 2'd0,
      MODE_PLAY = 2'd1,
      MODE_STOP = 2'd2
   } mode_type;

   // Fade curves; the unused code behaves as linear
   typedef enum logic [SHAPE_W-1:0] {
      SHAPE_LINEAR      = 2'd0,
      SHAPE_EQUAL_POWER = 2'd1,
      SHAPE_OUT_THEN_IN = 2'd2
   } shape_type;

   // Fader state as reported on the result channel
   typedef enum logic [STATE_W-1:0] {
      FS_IDLE     = 3'd0,
      FS_FADE_IN  = 3'd1,
      FS_PLAYING  = 3'd2,
      FS_XFADE    = 3'd3,
      FS_FADE_OUT = 3'd4
   } fader_state_type;

   // Sequencer states
   typedef enum logic [3:0] {
      CTL_IDLE,
      CTL_EXEC,
      CTL_FRAC,
      CTL_DIV,
      CTL_APPLY,
      CTL_SQA,
      CTL_SQB,
      CTL_DONE
   } ctl_state_type;

   // Operations of the shift-subtract unit
   typedef enum logic {
      UOP_DIV  = 1'b0,
      UOP_SQRT = 1'b1
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

`default_nettype wire

// ===== hdl/music_crossfade_controller_unit.sv =====
// Top level of the two-track music crossfade controller.
//
//   channel | direction | tdata fields (low bit first)                        | tuser
//   req     | in        | elapsed_us, fade_in_us, fade_out_us, fade_shape,     | mode
//           |           | track_id                                             |
//   rsp     | out       | fader_state, volume_a, volume_b, track_a, track_b    | -
//
// Play, stop, an ignored code or a tick while idle go from capture straight to the result.
// Any other tick runs the divider, skipped when the fade is already complete, then none,
// one or two square roots, all on the single shift-subtract unit.
// Reset is synchronous; no clearing pass.
// A result waiting in the output register holds off only the next completion.
`default_nettype none

module music_crossfade_controller_unit #(
   parameter int GAIN_FRAC_BITS = 16,
   parameter int TRACK_BITS     = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // elapsed_us, fade_in_us, fade_out_us, fade_shape, track_id, zero pad
   input  logic [((mcf_pkg::ELAPSED_W + 2 * mcf_pkg::LEN_W + mcf_pkg::SHAPE_W
                   + TRACK_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // mode
   input  logic [mcf_pkg::MODE_W-1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // fader_state, volume_a, volume_b, track_a, track_b, zero pad
   output logic [((mcf_pkg::STATE_W + 2 * (GAIN_FRAC_BITS + 1)
                   + 2 * TRACK_BITS + 7) / 8) * 8 - 1:0] rsp_tdata
);
   import mcf_pkg::*;

   localparam int GW        = GAIN_FRAC_BITS + 1;
   localparam int RSP_W     = ((STATE_W + 2 * GW + 2 * TRACK_BITS + 7) / 8) * 8;
   localparam int OFS_FIN   = ELAPSED_W;
   localparam int OFS_FOUT  = OFS_FIN + LEN_W;
   localparam int OFS_SHAPE = OFS_FOUT + LEN_W;
   localparam int OFS_TRACK = OFS_SHAPE + SHAPE_W;

   localparam logic [GW-1:0] GAIN_ONE  = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
   localparam logic [GW-1:0] GAIN_HALF = {2'b01, {(GAIN_FRAC_BITS - 1){1'b0}}};

   // Sequencer and captured request
   ctl_state_type          ctl_ff, ctl_in;
   mode_type               cmd_mode_ff, cmd_mode_in;
   logic [ELAPSED_W-1:0]   cmd_elapsed_ff, cmd_elapsed_in;
   logic [LEN_W-1:0]       cmd_fin_ff, cmd_fin_in;
   logic [LEN_W-1:0]       cmd_fout_ff, cmd_fout_in;
   shape_type              cmd_shape_ff, cmd_shape_in;
   logic [TRACK_BITS-1:0]  cmd_track_ff, cmd_track_in;

   // Fader state
   fader_state_type        fader_ff, fader_in;
   logic [TIMER_W-1:0]     timer_ff, timer_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   shape_type              shape_ff, shape_in;
   logic [GW-1:0]          gain_a_ff, gain_a_in;
   logic [GW-1:0]          gain_b_ff, gain_b_in;
   logic [TRACK_BITS-1:0]  cur_track_ff, cur_track_in;
   logic [TRACK_BITS-1:0]  nxt_track_ff, nxt_track_in;
   logic [GW-1:0]          t_ff, t_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   // Shared unit
   unit_ctl_type           unit_ctl;
   unit_sts_type           unit_sts;
   logic [GW-1:0]          unit_radicand;
   logic [GW-1:0]          unit_result;

   logic                   req_fire;
   logic                   out_free;
   logic [LEN_W:0]         play_sum;
   logic [LEN_W-1:0]       play_len;
   logic [LEN_W-1:0]       play_len_fl;
   logic [LEN_W-1:0]       stop_len_fl;
   logic [TIMER_W:0]       timer_sum;
   logic [TIMER_W-1:0]     timer_sat;
   logic                   frac_full;
   logic                   fade_done;
   logic                   need_sqrt;
   logic [GW-1:0]          t_minus_half;

   // Helpers
   assign req_fire     = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign play_sum     = {1'b0, cmd_fin_ff} + {1'b0, cmd_fout_ff};
   assign play_len     = play_sum[LEN_W:1];
   assign play_len_fl  = (play_len < FADE_FLOOR_US) ? FADE_FLOOR_US : play_len;
   assign stop_len_fl  = (cmd_fout_ff < FADE_FLOOR_US) ? FADE_FLOOR_US : cmd_fout_ff;
   assign timer_sum    = {1'b0, timer_ff} + (TIMER_W + 1)'(cmd_elapsed_ff);
   assign timer_sat    = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
   assign frac_full    = (len_ff == '0) || (timer_ff >= TIMER_W'(len_ff));
   assign fade_done    = (t_ff == GAIN_ONE);
   assign need_sqrt    = (shape_ff == SHAPE_EQUAL_POWER) &&
                         ((fader_ff == FS_FADE_IN) || ((fader_ff == FS_XFADE) && !fade_done));
   assign t_minus_half = t_ff - GAIN_HALF;

   // Sequencer next state
   always_comb begin
      ctl_in = ctl_ff;
      unique case (ctl_ff)
         CTL_IDLE:  if (req_fire) ctl_in = CTL_EXEC;
         CTL_EXEC: begin
            if ((cmd_mode_ff == MODE_TICK) && (fader_ff != FS_IDLE)) ctl_in = CTL_FRAC;
            else ctl_in = CTL_DONE;
         end
         CTL_FRAC:  ctl_in = frac_full ? CTL_APPLY : CTL_DIV;
         CTL_DIV:   if (unit_sts.done) ctl_in = CTL_APPLY;
         CTL_APPLY: ctl_in = need_sqrt ? CTL_SQA : CTL_DONE;
         CTL_SQA: begin
            if (unit_sts.done) ctl_in = (fader_ff == FS_XFADE) ? CTL_SQB : CTL_DONE;
         end
         CTL_SQB:   if (unit_sts.done) ctl_in = CTL_DONE;
         CTL_DONE:  if (out_free) ctl_in = CTL_IDLE;
         default:   ctl_in = CTL_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready    = 1'b0;
      unit_ctl      = '{start: 1'b0, op: UOP_DIV};
      unit_radicand = t_ff;
      unique case (ctl_ff)
         CTL_IDLE:  req_tready = 1'b1;
         CTL_FRAC:  unit_ctl = '{start: !frac_full, op: UOP_DIV};
         CTL_APPLY: begin
            unit_ctl = '{start: need_sqrt, op: UOP_SQRT};
            if (fader_ff == FS_XFADE) unit_radicand = GAIN_ONE - t_ff;
         end
         CTL_SQA: begin
            unit_ctl = '{start: unit_sts.done && (fader_ff == FS_XFADE), op: UOP_SQRT};
         end
         default: ;
      endcase
   end

   // Fader state and result updates
   always_comb begin
      cmd_mode_in    = cmd_mode_ff;
      cmd_elapsed_in = cmd_elapsed_ff;
      cmd_fin_in     = cmd_fin_ff;
      cmd_fout_in    = cmd_fout_ff;
      cmd_shape_in   = cmd_shape_ff;
      cmd_track_in   = cmd_track_ff;
      fader_in       = fader_ff;
      timer_in       = timer_ff;
      len_in         = len_ff;
      shape_in       = shape_ff;
      gain_a_in      = gain_a_ff;
      gain_b_in      = gain_b_ff;
      cur_track_in   = cur_track_ff;
      nxt_track_in   = nxt_track_ff;
      t_in           = t_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      unique case (ctl_ff)
         CTL_IDLE: begin
            if (req_fire) begin
               cmd_mode_in    = mode_type'(req_tuser);
               cmd_elapsed_in = req_tdata[ELAPSED_W-1:0];
               cmd_fin_in     = req_tdata[OFS_FIN +: LEN_W];
               cmd_fout_in    = req_tdata[OFS_FOUT +: LEN_W];
               cmd_shape_in   = shape_type'(req_tdata[OFS_SHAPE +: SHAPE_W]);
               cmd_track_in   = req_tdata[OFS_TRACK +: TRACK_BITS];
            end
         end
         CTL_EXEC: begin
            unique case (cmd_mode_ff)
               MODE_PLAY: begin
                  len_in   = play_len_fl;
                  timer_in = '0;
                  shape_in = cmd_shape_ff;
                  if ((fader_ff == FS_PLAYING) || (fader_ff == FS_FADE_IN)) begin
                     nxt_track_in = cmd_track_ff;
                     fader_in     = FS_XFADE;
                  end else begin
                     cur_track_in = cmd_track_ff;
                     nxt_track_in = '0;
                     gain_a_in    = '0;
                     fader_in     = FS_FADE_IN;
                  end
               end
               MODE_STOP: begin
                  len_in   = stop_len_fl;
                  timer_in = '0;
                  fader_in = FS_FADE_OUT;
               end
               MODE_TICK: if (fader_ff != FS_IDLE) timer_in = timer_sat;
               default: ;
            endcase
         end
         CTL_FRAC: if (frac_full) t_in = GAIN_ONE;
         CTL_DIV:  if (unit_sts.done) t_in = unit_result;
         CTL_APPLY: begin
            unique case (fader_ff)
               FS_FADE_IN: begin
                  if (shape_ff != SHAPE_EQUAL_POWER) begin
                     gain_a_in = t_ff;
                     if (fade_done) fader_in = FS_PLAYING;
                  end
               end
               FS_PLAYING: gain_a_in = GAIN_ONE;
               FS_XFADE: begin
                  if (fade_done) begin
                     cur_track_in = nxt_track_ff;
                     nxt_track_in = '0;
                     gain_a_in    = GAIN_ONE;
                     gain_b_in    = '0;
                     fader_in     = FS_PLAYING;
                  end else begin
                     case (shape_ff)
                        SHAPE_EQUAL_POWER: ;
                        SHAPE_OUT_THEN_IN: begin
                           if (t_ff < GAIN_HALF) begin
                              gain_a_in = GAIN_ONE - {t_ff[GW-2:0], 1'b0};
                              gain_b_in = '0;
                           end else begin
                              gain_a_in = '0;
                              gain_b_in = {t_minus_half[GW-2:0], 1'b0};
                           end
                        end
                        default: begin
                           gain_a_in = GAIN_ONE - t_ff;
                           gain_b_in = t_ff;
                        end
                     endcase
                  end
               end
               FS_FADE_OUT: begin
                  if (fade_done) begin
                     cur_track_in = '0;
                     gain_a_in    = '0;
                     fader_in     = FS_IDLE;
                  end else begin
                     gain_a_in = GAIN_ONE - t_ff;
                  end
               end
               default: ;
            endcase
         end
         CTL_SQA: begin
            if (unit_sts.done) begin
               gain_a_in = unit_result;
               if ((fader_ff == FS_FADE_IN) && fade_done) fader_in = FS_PLAYING;
            end
         end
         CTL_SQB: if (unit_sts.done) gain_b_in = unit_result;
         CTL_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({nxt_track_ff, cur_track_ff, gain_b_ff, gain_a_ff,
                                      fader_ff});
            end
         end
         default: ;
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
         fader_ff     <= FS_IDLE;
         timer_ff     <= '0;
         len_ff       <= '0;
         shape_ff     <= SHAPE_LINEAR;
         gain_a_ff    <= '0;
         gain_b_ff    <= '0;
         cur_track_ff <= '0;
         nxt_track_ff <= '0;
      end else begin
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
         fader_ff     <= fader_in;
         timer_ff     <= timer_in;
         len_ff       <= len_in;
         shape_ff     <= shape_in;
         gain_a_ff    <= gain_a_in;
         gain_b_ff    <= gain_b_in;
         cur_track_ff <= cur_track_in;
         nxt_track_ff <= nxt_track_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_mode_ff    <= cmd_mode_in;
      cmd_elapsed_ff <= cmd_elapsed_in;
      cmd_fin_ff     <= cmd_fin_in;
      cmd_fout_ff    <= cmd_fout_in;
      cmd_shape_ff   <= cmd_shape_in;
      cmd_track_ff   <= cmd_track_in;
      t_ff           <= t_in;
      rsp_data_ff    <= rsp_data_in;
   end

   mcf_shift_sub_unit #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_shift_sub (
      .clock    (clock),
      .reset    (reset),
      .ctl      (unit_ctl),
      .dividend (timer_ff[LEN_W-1:0]),
      .divisor  (len_ff),
      .radicand (unit_radicand),
      .sts      (unit_sts),
      .result   (unit_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Idle means no track and silence
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (fader_ff == FS_IDLE) |-> (gain_a_ff == '0) && (cur_track_ff == '0))
      else $error("idle with a live track");

   // Gains stay within unity
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      (gain_a_ff <= GAIN_ONE) && (gain_b_ff <= GAIN_ONE))
      else $error("gain above unity");

   // Ready only while the shared unit is free
   a_ready_unit: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !unit_sts.busy)
      else $error("request taken while unit busy");

   // Wait states always have a live or finished operation
   a_wait_live: assert property (@(posedge clock) disable iff (reset)
      ((ctl_ff == CTL_DIV) || (ctl_ff == CTL_SQA) || (ctl_ff == CTL_SQB))
      |-> (unit_sts.busy || unit_sts.done))
      else $error("waiting on an idle unit");

endmodule

`default_nettype wire

// ===== hdl/mcf_shift_sub_unit.sv =====
// Shared shift-subtract unit: fraction divider and integer square root.
`default_nettype none

module mcf_shift_sub_unit #(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mcf_pkg::unit_ctl_type         ctl,
   input  logic [mcf_pkg::LEN_W-1:0]     dividend,   // must be below divisor
   input  logic [mcf_pkg::LEN_W-1:0]     divisor,
   input  logic [GAIN_FRAC_BITS:0]       radicand,   // Q1.F value
   output mcf_pkg::unit_sts_type         sts,
   output logic [GAIN_FRAC_BITS:0]       result
);
   import mcf_pkg::*;

   localparam int GW    = GAIN_FRAC_BITS + 1;
   localparam int ACC_W = (GAIN_FRAC_BITS + 4 > LEN_W + 1) ? GAIN_FRAC_BITS + 4 : LEN_W + 1;
   localparam int RAD_W = 2 * GW;
   localparam int CNT_W = $clog2(GW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   unit_op_type       op_ff, op_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [GW-1:0]     root_ff, root_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [LEN_W-1:0]  div_ff, div_in;

   logic [ACC_W-1:0]  sub_a;
   logic [ACC_W-1:0]  sub_b;
   logic [ACC_W:0]    diff;
   logic              fits;

   // The one subtractor; operands depend on the operation
   always_comb begin
      if (op_ff == UOP_SQRT) begin
         sub_a = {acc_ff[ACC_W-3:0], rad_ff[RAD_W-1 -: 2]};
         sub_b = ACC_W'({root_ff, 2'b01});
      end else begin
         sub_a = {acc_ff[ACC_W-2:0], 1'b0};
         sub_b = ACC_W'(div_ff);
      end
      diff = {1'b0, sub_a} - {1'b0, sub_b};
      fits = !diff[ACC_W];
   end

   // One quotient or root bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      root_in = root_ff;
      rad_in  = rad_ff;
      div_in  = div_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         op_in   = ctl.op;
         root_in = '0;
         div_in  = divisor;
         if (ctl.op == UOP_SQRT) begin
            acc_in = '0;
            rad_in = {1'b0, radicand, {GAIN_FRAC_BITS{1'b0}}};
            cnt_in = CNT_W'(GAIN_FRAC_BITS);
         end else begin
            acc_in = ACC_W'(dividend);
            cnt_in = CNT_W'(GAIN_FRAC_BITS - 1);
         end
      end else if (busy_ff) begin
         acc_in  = fits ? diff[ACC_W-1:0] : sub_a;
         root_in = {root_ff[GW-2:0], fits};
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= UOP_DIV;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
      div_ff  <= div_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = root_ff;

   // A new operation never lands on one still running
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff)
      else $error("start while unit busy");

endmodule

`default_nettype wire

// ===== tb/sv/mcf_fader_checker.sv =====
// Request/response monitor with a fader predictor for the crossfade controller.
`timescale 1ns / 1ps

module mcf_fader_checker #(
   parameter int REQ_W = 88,
   parameter int RSP_W = 72
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   // elapsed_us, fade_in_us, fade_out_us, fade_shape, track_id, zero pad
   input  logic [REQ_W-1:0] req_tdata,
   // mode
   input  logic [mcf_pkg::MODE_W-1:0] req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   // fader_state, volume_a, volume_b, track_a, track_b, zero pad
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               mismatches,
   output int               pending
);
   import mcf_pkg::*;

   localparam logic [16:0] GAIN_UNITY = 17'h10000;
   localparam logic [16:0] GAIN_MID   = 17'h08000;

   // What one response should show
   typedef struct {
      logic [STATE_W-1:0] state;
      logic [16:0]        vol_a;
      logic [16:0]        vol_b;
      logic [15:0]        trk_a;
      logic [15:0]        trk_b;
   } mix_status_type;

   mix_status_type status_due[$];
   mix_status_type status_want;

   // Predicted fader state
   fader_state_type fsm;
   logic [31:0]     timer;
   logic [23:0]     fade_len;
   logic [1:0]      curve;
   logic [16:0]     gain_a;
   logic [16:0]     gain_b;
   logic [15:0]     trk_cur;
   logic [15:0]     trk_next;

   // floor(sqrt(x * 2^16)), built one result bit at a time
   function automatic logic [16:0] gain_root(input logic [16:0] x);
      logic [63:0] target;
      logic [16:0] root;
      logic [16:0] trial;
      target = 64'(x) << 16;
      root   = '0;
      for (int i = 16; i >= 0; i--) begin
         trial = root | (17'd1 << i);
         if (64'(trial) * 64'(trial) <= target)
            root = trial;
      end
      return root;
   endfunction

   // Fade fraction in Q1.16, clamped to one
   function automatic logic [16:0] fade_progress();
      if (fade_len == '0 || timer >= 32'(fade_len))
         return GAIN_UNITY;
      return 17'((64'(timer) << 16) / 64'(fade_len));
   endfunction

   task automatic apply_request(input logic [MODE_W-1:0] mode, input logic [REQ_W-1:0] d);
      logic [15:0]    elapsed;
      logic [23:0]    fin;
      logic [23:0]    fout;
      logic [1:0]     shp;
      logic [15:0]    trk;
      logic [32:0]    sum;
      logic [24:0]    both;
      logic [16:0]    t;
      logic           done;
      mix_status_type due_entry;
      elapsed = d[15:0];
      fin     = d[39:16];
      fout    = d[63:40];
      shp     = d[65:64];
      trk     = d[81:66];
      case (mode)
         MODE_TICK: begin
            if (fsm != FS_IDLE) begin
               sum   = {1'b0, timer} + 33'(elapsed);
               timer = sum[32] ? '1 : sum[31:0];
               t     = fade_progress();
               done  = (t >= GAIN_UNITY);
               case (fsm)
                  FS_FADE_IN: begin
                     gain_a = (curve == SHAPE_EQUAL_POWER) ? gain_root(t) : t;
                     if (done)
                        fsm = FS_PLAYING;
                  end
                  FS_PLAYING: gain_a = GAIN_UNITY;
                  FS_XFADE: begin
                     if (done) begin
                        // crossfade complete: incoming track becomes current
                        trk_cur  = trk_next;
                        trk_next = '0;
                        gain_a   = GAIN_UNITY;
                        gain_b   = '0;
                        fsm      = FS_PLAYING;
                     end else if (curve == SHAPE_EQUAL_POWER) begin
                        gain_a = gain_root(GAIN_UNITY - t);
                        gain_b = gain_root(t);
                     end else if (curve == SHAPE_OUT_THEN_IN) begin
                        if (t < GAIN_MID) begin
                           gain_a = 17'(GAIN_UNITY - 2 * t);
                           gain_b = '0;
                        end else begin
                           gain_a = '0;
                           gain_b = 17'(2 * (t - GAIN_MID));
                        end
                     end else begin
                        gain_a = GAIN_UNITY - t;
                        gain_b = t;
                     end
                  end
                  FS_FADE_OUT: begin
                     if (done) begin
                        trk_cur = '0;
                        gain_a  = '0;
                        fsm     = FS_IDLE;
                     end else begin
                        gain_a = GAIN_UNITY - t;
                     end
                  end
                  default: ;
               endcase
            end
         end
         MODE_PLAY: begin
            both     = 25'(fin) + 25'(fout);
            fade_len = (both[24:1] < FADE_FLOOR_US) ? FADE_FLOOR_US : both[24:1];
            timer    = '0;
            curve    = shp;
            if (fsm == FS_PLAYING || fsm == FS_FADE_IN) begin
               trk_next = trk;
               fsm      = FS_XFADE;
            end else begin
               // fresh fade-in; gain_a starts from zero and gain_b is left as it was
               trk_cur  = trk;
               trk_next = '0;
               gain_a   = '0;
               fsm      = FS_FADE_IN;
            end
         end
         MODE_STOP: begin
            fade_len = (fout < FADE_FLOOR_US) ? FADE_FLOOR_US : fout;
            timer    = '0;
            fsm      = FS_FADE_OUT;
         end
         default: ;
      endcase
      due_entry = '{fsm, gain_a, gain_b, trk_cur, trk_next};
      status_due.insert(status_due.size(), due_entry);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
      if (want !== seen) begin
         $display("%t: %s expected %0d, got %0d", $time, name, want, seen);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fsm      = FS_IDLE;
         timer    = '0;
         fade_len = '0;
         curve    = SHAPE_LINEAR;
         gain_a   = '0;
         gain_b   = '0;
         trk_cur  = '0;
         trk_next = '0;
         status_due.delete();
      end else begin
         // responses first: none can belong to a request taken at this edge
         if (rsp_tvalid && rsp_tready) begin
            if (status_due.size() == 0) begin
               $display("%t: response with nothing outstanding, expected none, got %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               status_want = status_due.pop_front();
               check_field("fader_state", 32'(status_want.state), 32'(rsp_tdata[2:0]));
               check_field("volume_a", 32'(status_want.vol_a), 32'(rsp_tdata[19:3]));
               check_field("volume_b", 32'(status_want.vol_b), 32'(rsp_tdata[36:20]));
               check_field("track_a", 32'(status_want.trk_a), 32'(rsp_tdata[52:37]));
               check_field("track_b", 32'(status_want.trk_b), 32'(rsp_tdata[68:53]));
            end
         end
         if (req_tvalid && req_tready)
            apply_request(req_tuser, req_tdata);
      end
      pending <= status_due.size();
   end

endmodule

// ===== tb/sv/music_crossfade_controller_unit_tb.sv =====
// Stimulus, idling control and verdict for the music crossfade controller.
`timescale 1ns / 1ps

module music_crossfade_controller_unit_tb;
   import mcf_pkg::*;

   localparam int TRACK_W = 16;
   localparam int GAIN_W  = 17;
   localparam int REQ_W   = ((ELAPSED_W + 2 * LEN_W + SHAPE_W + TRACK_W + 7) / 8) * 8;
   localparam int RSP_W   = ((STATE_W + 2 * GAIN_W + 2 * TRACK_W + 7) / 8) * 8;

   // Codes the block accepts but does not name
   localparam logic [MODE_W-1:0]  MODE_SPARE  = 2'd3;
   localparam logic [SHAPE_W-1:0] SHAPE_SPARE = 2'd3;

   localparam int ITEM_GOAL      = 1900;
   localparam int RSP_HOLD_LEN   = 400;
   localparam int DRAIN_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT = 4000;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0] req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   int mismatches;
   int pending;
   int sent;
   int sender_idle_pct;
   int rsp_stall_pct;
   int rsp_hold_req;
   int rsp_hold_left;
   int quiet_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   music_crossfade_controller_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mcf_fader_checker #(.REQ_W(REQ_W), .RSP_W(RSP_W)) u_fader_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // Receiver: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (rsp_hold_req > 0) begin
         rsp_hold_left = rsp_hold_req;
         rsp_hold_req  = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog on cycles with no request or response moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("music_crossfade_controller_unit test failed");
         $finish;
      end
   end

   // Offer one request and return at the edge that takes it
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [15:0] elapsed,
                               input logic [23:0] fin, input logic [23:0] fout,
                               input logic [SHAPE_W-1:0] shp, input logic [15:0] trk);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_W'({trk, shp, fout, fin, elapsed});
      @(negedge clock);
      while (!req_tready)
         @(negedge clock);
      @(posedge clock);
      if (mode != MODE_SPARE)
         sent++;
   endtask

   // Mostly fades short enough to finish within a handful of ticks
   function automatic logic [23:0] pick_fade_us();
      case ($urandom_range(19))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return 24'($urandom);
         default: return 24'($urandom_range(60000));
      endcase
   endfunction

   function automatic logic [15:0] pick_elapsed();
      case ($urandom_range(9))
         0:          return '1;
         1:          return '0;
         2, 3, 4, 5: return 16'($urandom);
         default:    return 16'($urandom_range(4000));
      endcase
   endfunction

   initial begin
      int goal;
      int ticks;
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle corner cases
      send_request(MODE_TICK, '1, '0, '0, SHAPE_LINEAR, '0);
      send_request(MODE_SPARE, 16'h1234, '1, '1, SHAPE_SPARE, '1);
      send_request(MODE_STOP, '0, '0, '0, SHAPE_LINEAR, '0);
      send_request(MODE_TICK, 16'd5000, '0, '0, SHAPE_LINEAR, '0);
      send_request(MODE_TICK, '1, '0, '0, SHAPE_LINEAR, '0);
      // equal-power fade-in up to playing
      send_request(MODE_PLAY, '0, '0, '0, SHAPE_EQUAL_POWER, '1);
      send_request(MODE_TICK, 16'd2500, '0, '0, SHAPE_LINEAR, '0);
      send_request(MODE_TICK, '0, '0, '0, SHAPE_LINEAR, '0);
      send_request(MODE_TICK, '1, '0, '0, SHAPE_LINEAR, '0);
      send_request(MODE_TICK, 16'd1, '0, '0, SHAPE_LINEAR, '0);
      // longest out-then-in crossfade, cut short by a play with the spare shape
      send_request(MODE_PLAY, '0, '1, '1, SHAPE_OUT_THEN_IN, 16'd1);
      send_request(MODE_TICK, '1, '0, '0, SHAPE_LINEAR, '0);
      send_request(MODE_TICK, '1, '0, '0, SHAPE_LINEAR, '0);
      send_request(MODE_PLAY, '0, '0, 24'd19998, SHAPE_SPARE, '0);
      // crossfade from fading in, run to completion
      send_request(MODE_PLAY, '0, 24'd20000, '0, SHAPE_LINEAR, 16'd2);
      send_request(MODE_TICK, 16'd3000, '0, '0, SHAPE_LINEAR, '0);
      send_request(MODE_TICK, 16'd4000, '0, '0, SHAPE_LINEAR, '0);
      send_request(MODE_TICK, '1, '0, '0, SHAPE_LINEAR, '0);
      // equal-power crossfade
      send_request(MODE_PLAY, '0, 24'd10000, 24'd10000, SHAPE_EQUAL_POWER, 16'h8000);
      send_request(MODE_TICK, 16'd5000, '0, '0, SHAPE_LINEAR, '0);
      send_request(MODE_TICK, 16'd5000, '0, '0, SHAPE_LINEAR, '0);
      // out-then-in either side of the midpoint
      send_request(MODE_PLAY, '0, 24'd20000, 24'd20000, SHAPE_OUT_THEN_IN, 16'd3);
      send_request(MODE_TICK, 16'd5000, '0, '0, SHAPE_LINEAR, '0);
      send_request(MODE_TICK, 16'd10000, '0, '0, SHAPE_LINEAR, '0);
      // fade-out restarted, then play while fading out
      send_request(MODE_STOP, '0, '0, '1, SHAPE_LINEAR, '0);
      send_request(MODE_TICK, '1, '0, '0, SHAPE_LINEAR, '0);
      send_request(MODE_STOP, '0, '0, 24'd30000, SHAPE_LINEAR, '0);
      send_request(MODE_PLAY, '0, '0, '0, SHAPE_LINEAR, 16'd5);

      // Random: well-formed play/stop sequences with ticks, plus noise
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 70; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 70; end
            default: begin sender_idle_pct = 26; rsp_stall_pct = 26; end
         endcase
         // long receiver hold-off so the block backs up into the request side
         if (ph == 0)
            rsp_hold_req = RSP_HOLD_LEN;
         goal = ITEM_GOAL * (ph + 1) / 4;
         while (sent < goal) begin
            if ($urandom_range(9) < 7) begin
               send_request(($urandom_range(3) == 0) ? MODE_STOP : MODE_PLAY,
                            16'($urandom), pick_fade_us(), pick_fade_us(),
                            2'($urandom), 16'($urandom));
               ticks = $urandom_range(1, 10);
               repeat (ticks)
                  send_request(MODE_TICK, pick_elapsed(), 24'($urandom), 24'($urandom),
                               2'($urandom), 16'($urandom));
            end else begin
               send_request(2'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
                            2'($urandom), 16'($urandom));
            end
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then allow the block's latency to pass
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("music_crossfade_controller_unit test passed");
      else
         $display("music_crossfade_controller_unit test failed");
      $finish;
   end

endmodule
